[rtl/nflp_pkg.sv]
// Shared types, tap constants and tap scaling for the normalised low-pass FIR.
package nflp_pkg;

    localparam int BASE_FRAC = 17;
    localparam int BASE_TAPS = 43;
    localparam int HALF_LEN  = 22;

    // Taps 0..21 in Q1.17; the filter is symmetric, tap k equals tap 42-k.
    localparam int HALF_TAPS [HALF_LEN] = '{
        273, 759, 1615, 2821, 4234, 5554, 6359, 6200, 4746, 1939, -1890,
        -5988, -9284, -10599, -8945, -3825, 4545, 15183, 26470, 36471,
        43352, 45803
    };

    // Control shared by every cell of the sample chain.
    typedef struct packed {
        logic load;   // shift a new sample in at the head
        logic rot;    // rotate the ring by one place towards the head
    } cell_ctrl_t;

    // Tap k rescaled to frac fractional bits, rounding half away from zero.
    function automatic int coeff_of(input int k, input int frac);
        int q;
        int mag;
        int sh;
        if (k >= BASE_TAPS) begin
            q = 0;
        end else if (k < HALF_LEN) begin
            q = HALF_TAPS[k];
        end else begin
            q = HALF_TAPS[BASE_TAPS - 1 - k];
        end
        if (frac >= BASE_FRAC) begin
            return q <<< (frac - BASE_FRAC);
        end
        sh  = BASE_FRAC - frac;
        mag = (q < 0) ? -q : q;
        mag = (mag + (1 << (sh - 1))) >> sh;
        return (q < 0) ? -mag : mag;
    endfunction

endpackage

[rtl/nflp_cell.sv]
// One sample cell of the history ring.
module nflp_cell #(
    parameter int W = 24
) (
    input  logic                     aclk,
    input  nflp_pkg::cell_ctrl_t     ctrl,
    input  logic signed [W-1:0]      from_prev,
    input  logic signed [W-1:0]      from_next,
    output logic signed [W-1:0]      data_out
);

    logic signed [W-1:0] data_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            data_reg <= from_prev;
        end else if (ctrl.rot) begin
            data_reg <= from_next;
        end
    end

    assign data_out = data_reg;

endmodule

[rtl/nflp_mac.sv]
// Shared multiply-accumulate and running sum of used tap magnitudes.
module nflp_mac #(
    parameter int W  = 24,
    parameter int CW = 17,
    parameter int AW = 47,
    parameter int DW = 23
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  clear,
    input  logic                  en,
    input  logic signed [W-1:0]   sample,
    input  logic signed [CW-1:0]  coef,
    output logic signed [AW-1:0]  acc,
    output logic [DW-1:0]         dsum
);

    logic signed [W+CW-1:0] prod_reg;
    logic                   prod_vld_reg;
    logic signed [AW-1:0]   acc_reg;
    logic [DW-1:0]          dsum_reg;
    logic [CW-1:0]          coef_abs;

    assign coef_abs = coef[CW-1] ? CW'(-coef) : CW'(coef);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_vld_reg <= 1'b0;
        end else begin
            prod_vld_reg <= en;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= sample * coef;
        end
        if (clear) begin
            acc_reg  <= '0;
            dsum_reg <= '0;
        end else begin
            if (prod_vld_reg) begin
                acc_reg <= acc_reg + AW'(prod_reg);
            end
            if (en) begin
                dsum_reg <= dsum_reg + DW'(coef_abs);
            end
        end
    end

    assign acc  = acc_reg;
    assign dsum = dsum_reg;

endmodule

[rtl/nflp_div.sv]
// Restoring divider, one quotient bit a cycle, truncating toward zero and saturating.
module nflp_div #(
    parameter int AW = 47,
    parameter int DW = 23,
    parameter int QW = 24
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic signed [AW-1:0]  dividend,
    input  logic [DW-1:0]         divisor,
    output logic                  done,
    output logic signed [QW-1:0]  quotient
);

    localparam int CNTW = $clog2(QW + 1);

    logic            busy_reg;
    logic            done_reg;
    logic [CNTW-1:0] cnt_reg;
    logic [DW:0]     rem_reg;
    logic [QW-1:0]   dnd_reg;
    logic [DW-1:0]   dvs_reg;
    logic            neg_reg;
    logic            zero_reg;

    logic [AW-1:0]   mag;
    logic [DW:0]     trial;
    logic            qbit;

    assign mag   = dividend[AW-1] ? AW'(-dividend) : AW'(dividend);
    assign trial = {rem_reg[DW-1:0], dnd_reg[QW-1]};
    assign qbit  = (trial >= {1'b0, dvs_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= CNTW'(cnt_reg + 1'b1);
                if (cnt_reg == CNTW'(QW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= (DW+1)'(mag >> QW);
            dnd_reg  <= mag[QW-1:0];
            dvs_reg  <= divisor;
            neg_reg  <= dividend[AW-1];
            zero_reg <= (divisor == '0);
        end else if (busy_reg) begin
            rem_reg <= qbit ? (trial - {1'b0, dvs_reg}) : trial;
            dnd_reg <= {dnd_reg[QW-2:0], qbit};
        end
    end

    always_comb begin
        if (zero_reg) begin
            quotient = '0;
        end else if (neg_reg) begin
            quotient = QW'(-dnd_reg);
        end else if (dnd_reg[QW-1]) begin
            quotient = {1'b0, {(QW-1){1'b1}}};
        end else begin
            quotient = dnd_reg;
        end
    end

    assign done = done_reg;

endmodule

[rtl/normalized_fir_lowpass_43tap_unit.sv]
// Top level of the normalised symmetric low-pass FIR: cell ring, shared MAC, divider.
//
// Each transaction on the s_ side carries one signed sample and a block_start
// flag; exactly one filtered sample leaves on the m_ side for it. The samples
// sit in a ring of TAPS cells (the newest at the head). After a transaction is
// taken the ring rotates once round, one cell a cycle, feeding the head cell
// into a single shared multiplier with the matching tap, so the ring is back in
// place when the sum is complete. Taps that reach past the samples of the
// current block are masked to zero, and the magnitudes of the taps that are used
// are summed alongside to form the normaliser. The sum of products is then
// divided by that normaliser in a restoring divider that makes one quotient bit
// a cycle; the quotient truncates toward zero and saturates to SAMPLE_WIDTH bits.
// From acceptance until the block is ready again, a transaction passes the MAC
// loop over the taps, a step to flush the product register, a step to load the
// divider, one step per quotient bit, and the hand-over to the output register.
// s_ready is high only while the block is idle; a finished result may still wait
// in the output register while the next transaction is taken. block_start, or
// the first sample after reset, starts a new block.
module normalized_fir_lowpass_43tap_unit #(
    parameter int TAPS            = 43,
    parameter int SAMPLE_WIDTH    = 24,
    parameter int COEFF_FRAC_BITS = 17
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] s_sample,
    input  logic                           s_block_start,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [SAMPLE_WIDTH-1:0] m_filtered
);

    // Coefficient magnitudes stay below 2^(COEFF_FRAC_BITS-1); the sum of
    // magnitudes of at most 43 non-zero taps stays below 2^(COEFF_FRAC_BITS+5).
    localparam int CW = COEFF_FRAC_BITS;
    localparam int DW = COEFF_FRAC_BITS + 6;
    localparam int AW = SAMPLE_WIDTH + DW;
    localparam int FW = (TAPS > 1) ? $clog2(TAPS) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAC,
        S_DRAIN,
        S_START,
        S_DIV,
        S_HOLD
    } state_t;

    state_t                   state_reg;
    logic [FW-1:0]            fill_reg;       // valid history entries, saturates at TAPS-1
    logic [FW-1:0]            fill_used_reg;  // taps above this one are masked
    logic [FW-1:0]            tap_reg;
    logic                     m_valid_reg;
    logic [SAMPLE_WIDTH-1:0]  m_filtered_reg;

    logic                     s_accept;
    logic [FW-1:0]            fill_use;
    nflp_pkg::cell_ctrl_t     cell_ctrl;
    logic signed [SAMPLE_WIDTH-1:0] cell_data [TAPS];
    logic signed [CW-1:0]     coef_sel;
    logic signed [SAMPLE_WIDTH-1:0] mac_sample;
    logic signed [AW-1:0]     acc;
    logic [DW-1:0]            dsum;
    logic                     div_done;
    logic signed [SAMPLE_WIDTH-1:0] quotient;

    assign s_ready  = (state_reg == S_IDLE);
    assign s_accept = s_valid && s_ready;
    // A new block starts with no history in play.
    assign fill_use = s_block_start ? '0 : fill_reg;

    // Load at the head on acceptance; rotate towards the head while summing.
    assign cell_ctrl.load = s_accept;
    assign cell_ctrl.rot  = (state_reg == S_MAC);

    for (genvar k = 0; k < TAPS; k++) begin : g_cell
        localparam int NEXT = (k + 1) % TAPS;
        logic signed [SAMPLE_WIDTH-1:0] prev_data;

        if (k == 0) begin : g_head
            assign prev_data = s_sample;
        end else begin : g_body
            assign prev_data = cell_data[k-1];
        end

        nflp_cell #(
            .W (SAMPLE_WIDTH)
        ) u_cell (
            .aclk      (aclk),
            .ctrl      (cell_ctrl),
            .from_prev (prev_data),
            .from_next (cell_data[NEXT]),
            .data_out  (cell_data[k])
        );
    end

    // Mask taps that would reach samples from before the current block; drop the
    // sample as well, since cells never written since reset hold no value.
    always_comb begin
        if (tap_reg <= fill_used_reg) begin
            coef_sel   = CW'(nflp_pkg::coeff_of(int'(tap_reg), COEFF_FRAC_BITS));
            mac_sample = cell_data[0];
        end else begin
            coef_sel   = '0;
            mac_sample = '0;
        end
    end

    nflp_mac #(
        .W  (SAMPLE_WIDTH),
        .CW (CW),
        .AW (AW),
        .DW (DW)
    ) u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (s_accept),
        .en      (state_reg == S_MAC),
        .sample  (mac_sample),
        .coef    (coef_sel),
        .acc     (acc),
        .dsum    (dsum)
    );

    nflp_div #(
        .AW (AW),
        .DW (DW),
        .QW (SAMPLE_WIDTH)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (state_reg == S_START),
        .dividend (acc),
        .divisor  (dsum),
        .done     (div_done),
        .quotient (quotient)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            fill_used_reg <= '0;
            tap_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            // Drop the output transaction once it has been taken, unless a new
            // result takes its place on the same edge.
            if (m_valid_reg && m_ready && (state_reg != S_HOLD)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_accept) begin
                        fill_used_reg <= fill_use;
                        fill_reg      <= (fill_use < FW'(TAPS - 1)) ?
                                         FW'(fill_use + 1'b1) : fill_use;
                        tap_reg       <= '0;
                        state_reg     <= S_MAC;
                    end
                end
                S_MAC: begin
                    tap_reg <= FW'(tap_reg + 1'b1);
                    if (tap_reg == FW'(TAPS - 1)) begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    state_reg <= S_START;
                end
                S_START: begin
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        state_reg <= S_HOLD;
                    end
                end
                S_HOLD: begin
                    // Hold until the output register is free.
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg    <= 1'b1;
                        m_filtered_reg <= quotient;
                        state_reg      <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_filtered = m_filtered_reg;

endmodule

[test/lowpass_output_checker.sv]
// Predicts and checks every filtered sample of the normalised 43-tap low-pass FIR.
module lowpass_output_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  logic signed [23:0]  s_sample,
    input  logic                s_block_start,
    input  logic                m_valid,
    input  logic                m_ready,
    input  logic signed [23:0]  m_filtered,
    output int                  mismatches,
    output int                  outstanding
);

    localparam int NUM_TAPS  = 43;
    localparam int W         = 24;
    localparam int MAX_LINES = 20;

    int                 half_q17 [22];
    int                 tap_q17 [NUM_TAPS];
    longint             norm_by_fill [NUM_TAPS];
    logic signed [W-1:0] past_samples [NUM_TAPS-1];
    int                 fill_level;
    logic signed [W-1:0] expected_filtered [$];
    logic signed [W-1:0] oldest;
    int                 printed;

    initial begin
        longint running;
        half_q17 = '{273, 759, 1615, 2821, 4234, 5554, 6359, 6200, 4746, 1939, -1890,
                     -5988, -9284, -10599, -8945, -3825, 4545, 15183, 26470, 36471,
                     43352, 45803};
        running = 0;
        for (int k = 0; k < NUM_TAPS; k++) begin
            tap_q17[k] = (k < 22) ? half_q17[k] : half_q17[NUM_TAPS - 1 - k];
            running += (tap_q17[k] < 0) ? -tap_q17[k] : tap_q17[k];
            norm_by_fill[k] = running;
        end
    end

    // Filter one sample against the history, then shift it in.
    function automatic logic signed [W-1:0] filter_sample(input logic signed [W-1:0] x,
                                                          input logic start);
        longint acc;
        longint quot;
        if (start)
            fill_level = 0;
        acc = longint'(x) * tap_q17[0];
        for (int k = 1; k <= fill_level; k++)
            acc += longint'(past_samples[k-1]) * tap_q17[k];
        quot = acc / norm_by_fill[fill_level];
        if (quot > longint'(8388607))
            quot = 8388607;
        if (quot < -longint'(8388608))
            quot = -8388608;
        for (int k = NUM_TAPS - 2; k > 0; k--)
            past_samples[k] = past_samples[k-1];
        past_samples[0] = x;
        if (fill_level < NUM_TAPS - 1)
            fill_level++;
        return quot[W-1:0];
    endfunction

    task automatic report_mismatch(input string what, input logic signed [W-1:0] got,
                                   input logic signed [W-1:0] want);
        if (printed < MAX_LINES)
            $display("MISMATCH at %0t: %s: filtered %0d, expected %0d", $time, what, got, want);
        printed++;
        mismatches++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            fill_level = 0;
            for (int k = 0; k < NUM_TAPS - 1; k++)
                past_samples[k] = '0;
            expected_filtered.delete();
        end else begin
            // Retire the result first: a transaction taken on this edge cannot be the one leaving.
            if (m_valid && m_ready) begin
                if (expected_filtered.size() == 0) begin
                    report_mismatch("result with nothing expected", m_filtered, '0);
                end else begin
                    oldest = expected_filtered.pop_front();
                    if (m_filtered !== oldest)
                        report_mismatch("wrong filtered value", m_filtered, oldest);
                end
            end
            if (s_valid && s_ready)
                expected_filtered.push_back(filter_sample(s_sample, s_block_start));
        end
        outstanding <= expected_filtered.size();
    end

endmodule

[test/testbench.sv]
// Stimulus, handshake pacing and verdict for the normalised 43-tap low-pass FIR.
module testbench;

    localparam int W           = 24;
    localparam int NUM_TAPS    = 43;
    localparam int ITEM_TARGET = 700;
    // Longest correct quiet spell: the longest sender gap plus the long receiver hold
    // plus one pass through the filter; allow several times that.
    localparam int STALL_LIMIT = 4000;
    localparam int LONG_HOLD   = 500;
    localparam int TAIL_CYCLES = 120;

    localparam logic signed [W-1:0] MAX_S = 24'sh7FFFFF;
    localparam logic signed [W-1:0] MIN_S = 24'sh800000;

    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 s_valid       = 1'b0;
    logic                 s_ready;
    logic signed [W-1:0]  s_sample      = '0;
    logic                 s_block_start = 1'b0;
    logic                 m_valid;
    logic                 m_ready       = 1'b0;
    logic signed [W-1:0]  m_filtered;

    int mismatches;
    int outstanding;
    int samples_sent = 0;
    int quiet_cycles = 0;
    bit full_speed   = 1'b0;   // sender offers back to back while set
    bit hold_req     = 1'b0;   // ask the receiver for one long hold-off

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    normalized_fir_lowpass_43tap_unit DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_sample      (s_sample),
        .s_block_start (s_block_start),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_filtered    (m_filtered)
    );

    lowpass_output_checker u_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_sample      (s_sample),
        .s_block_start (s_block_start),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_filtered    (m_filtered),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 20);
        return $urandom_range(30, 200);
    endfunction

    // Sample values: full-range noise, the extremes, small values and single bits.
    function automatic logic signed [W-1:0] pick_sample();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return W'($urandom);
        if (r < 7) begin
            case ($urandom_range(0, 4))
                0: return MAX_S;
                1: return MIN_S;
                2: return '0;
                3: return -24'sd1;
                default: return 24'sd1;
            endcase
        end
        if (r < 9)
            return W'(int'($urandom_range(0, 2000)) - 1000);
        r = $urandom_range(0, 22);
        return $urandom_range(0, 1) ? (24'sd1 <<< r) : -(24'sd1 <<< r);
    endfunction

    // Taps 10..15 and their mirror images 27..32 are the negative lobes.
    function automatic bit tap_negative(input int k);
        return (k >= 10 && k <= 15) || (k >= 27 && k <= 32);
    endfunction

    // Offer one transaction and hold it until the block takes it.
    task automatic send_sample(input logic signed [W-1:0] smp, input logic start);
        int gap;
        gap = full_speed ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_sample      <= smp;
        s_block_start <= start;
        do @(posedge aclk); while (!s_ready);
        samples_sent++;
    endtask

    // Hold the sender until every expected result has come back.
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    // Receiver: ready in bursts with random stalls; one long hold-off on request.
    initial begin
        int run;
        int gap;
        bit held;
        held = 1'b0;
        forever begin
            if (hold_req && !held) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                held = 1'b1;
            end else begin
                run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                                  : $urandom_range(1, 40);
                m_ready <= 1'b1;
                repeat (run) @(posedge aclk);
                gap = pick_gap();
                if (gap > 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
        end
    end

    // Watchdog: end the run if neither channel moves for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int  blocks;
        int  len;
        int  r;
        bit  flip;
        blocks = 0;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: the first sample after reset without a start flag, then the extremes
        // with a growing history, a start flag mid-stream and alternating bit patterns.
        send_sample(24'sd1000, 1'b0);
        send_sample(MAX_S, 1'b0);
        send_sample(MIN_S, 1'b0);
        send_sample('0, 1'b0);
        send_sample(-24'sd1, 1'b0);
        send_sample(24'sd1, 1'b0);
        send_sample(MAX_S, 1'b0);
        send_sample(MAX_S, 1'b0);
        send_sample(MIN_S, 1'b1);
        send_sample(MIN_S, 1'b0);
        send_sample(MIN_S, 1'b0);
        send_sample(MAX_S, 1'b0);
        send_sample(24'sh555555, 1'b1);
        send_sample(24'shAAAAAA, 1'b0);
        send_sample(24'sh555555, 1'b0);
        send_sample(-24'sd1, 1'b0);
        send_sample(MAX_S, 1'b1);
        send_sample(MIN_S, 1'b1);
        send_sample('0, 1'b1);
        send_sample(24'sh123456, 1'b0);
        drain_results();

        // Random blocks: mostly well-formed with a start flag up front, some long enough
        // to fill the whole tap line, some with tap-matched extreme signs, plus noise.
        while (samples_sent < ITEM_TARGET) begin
            blocks++;
            full_speed = ($urandom_range(0, 4) == 0);
            r = $urandom_range(0, 99);
            if (blocks == 6) begin
                // Stall the receiver while offering a dozen transactions back to back.
                hold_req   = 1'b1;
                full_speed = 1'b1;
                for (int i = 0; i < 12; i++)
                    send_sample(pick_sample(), i == 0);
            end else if (r < 8) begin
                // Signs follow the taps so the sum heads for full scale.
                len  = $urandom_range(NUM_TAPS, NUM_TAPS + 5);
                flip = $urandom_range(0, 1);
                for (int i = 0; i < len; i++)
                    send_sample((tap_negative(i % NUM_TAPS) ^ flip) ? MIN_S : MAX_S, i == 0);
            end else begin
                if (r < 60)
                    len = $urandom_range(1, 45);
                else if (r < 88)
                    len = $urandom_range(NUM_TAPS, 90);
                else
                    len = $urandom_range(100, 200);
                for (int i = 0; i < len; i++) begin
                    if (i == 0)
                        send_sample(pick_sample(), $urandom_range(0, 19) != 0);
                    else
                        send_sample(pick_sample(), $urandom_range(0, 32) == 0);
                end
            end
            if (blocks == 12)
                drain_results();
        end

        full_speed = 1'b0;
        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (mismatches == 0 && outstanding == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[normalized_fir_lowpass_43tap_unit.f]
rtl/nflp_pkg.sv
rtl/nflp_cell.sv
rtl/nflp_mac.sv
rtl/nflp_div.sv
rtl/normalized_fir_lowpass_43tap_unit.sv
test/lowpass_output_checker.sv
test/testbench.sv
